>>> sv/reference_picture_list_manager_assert.svh
// assertion macros for the reference picture list manager checker
`ifndef REFERENCE_PICTURE_LIST_MANAGER_ASSERT_SVH
`define REFERENCE_PICTURE_LIST_MANAGER_ASSERT_SVH
// implication checked every cycle outside reset
`define RPL_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("rplm check failed");
// implication checked on the following cycle
`define RPL_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("rplm check failed");
`endif

>>> sv/rplm_pkg.sv
// ----------------------------------------------------------------------------
// rplm_pkg
// shared types and constants of the reference picture list manager
// ----------------------------------------------------------------------------
`default_nettype none
package rplm_pkg;
    localparam int SHORT_DEPTH = 16;
    localparam int LONG_DEPTH  = 16;
    localparam int SIW = $clog2(SHORT_DEPTH);
    localparam int LIW = $clog2(LONG_DEPTH);
    localparam int CW  = 5;

    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_SLIDE    = 3'd1;
    localparam logic [2:0] OP_UNUSED   = 3'd2;
    localparam logic [2:0] OP_RM_SHORT = 3'd3;
    localparam logic [2:0] OP_TO_LONG  = 3'd4;
    localparam logic [2:0] OP_RM_LONG  = 3'd5;
    localparam logic [2:0] OP_CLEAR    = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] MARK_USED  = 2'd3;
    localparam logic [1:0] MARK_NONE  = 2'd0;

    typedef struct packed {
        logic [16:0] num;
        logic        base;
        logic [1:0]  marking;
        logic [7:0]  handle;
        logic [2:0]  layer;
        logic        shown;
    } t_pic;

    // datapath commands
    // C_REL_SHORT, C_RM_LONG and C_CLR_LONG also emit a release transfer
    typedef enum logic [3:0] {
        C_NONE, C_LATCH, C_INSERT, C_SCAN_SHORT, C_KEY_LAST, C_KEY_SCAN,
        C_SHIFT, C_TO_LONG, C_RM_LONG, C_SCAN_LONG, C_CLR_LONG, C_EMIT,
        C_CLR_ALL, C_REL_SHORT
    } t_cmd;

    typedef struct packed {
        t_cmd           cmd;
        logic [SIW-1:0] sidx;
        logic [LIW-1:0] lidx;
        logic           ltab;  // long table select, base table when set
        logic           use_key;
        logic           rel_short; // emit release of short entry at sidx
    } t_ctl;

    typedef struct packed {
        logic          short_match;   // entry at sidx matches key or latched picture
        logic          short_unused;
        logic          long_used3;    // table entry at lidx has marking 3
        logic [CW-1:0] short_used;
    } t_sts;
endpackage
`default_nettype wire

>>> sv/rplm_datapath.sv
// ----------------------------------------------------------------------------
// rplm_datapath
// list storage, key register, counters and release output register
// ----------------------------------------------------------------------------
`default_nettype none
module rplm_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rplm_pkg::t_ctl i_ctl,
    input  wire rplm_pkg::t_pic i_pic,
    input  wire logic          i_rel,
    input  wire logic          i_last,
    input  wire logic [1:0]    i_status,
    output rplm_pkg::t_sts     o_sts,
    output logic               o_valid,
    output logic               o_release_valid,
    output logic [7:0]         o_release_handle,
    output logic [2:0]         o_release_layer,
    output logic               o_release_samples,
    output logic [4:0]         o_short_count,
    output logic [4:0]         o_long_count,
    output logic [4:0]         o_long_base_count,
    output logic [1:0]         o_status,
    output logic               o_last
);
    import rplm_pkg::*;

    t_pic r_short [SHORT_DEPTH];
    t_pic r_long  [LONG_DEPTH];
    t_pic r_lbase [LONG_DEPTH];
    logic [CW-1:0] r_su, r_lu, r_lbu;
    t_pic r_in;
    logic [16:0] r_knum;
    logic r_kbase;

    t_pic w_s, w_l;
    logic [16:0] w_num;
    logic w_base;
    logic w_emit;

    always_comb begin
        w_s = r_short[i_ctl.sidx];
        w_l = i_ctl.ltab ? r_lbase[i_ctl.lidx] : r_long[i_ctl.lidx];
        w_num  = i_ctl.use_key ? r_knum : r_in.num;
        w_base = i_ctl.use_key ? r_kbase : r_in.base;
        w_emit = (i_ctl.cmd == C_EMIT) || (i_ctl.cmd == C_REL_SHORT) ||
                 (i_ctl.cmd == C_RM_LONG) || (i_ctl.cmd == C_CLR_LONG);
        o_sts.short_match  = (w_s.num == w_num) && (w_s.base == w_base);
        o_sts.short_unused = (w_s.marking == MARK_NONE);
        o_sts.long_used3   = (w_l.marking == MARK_USED);
        o_sts.short_used   = r_su;
    end

    always_ff @(posedge i_clk) begin
        o_valid <= 1'b0;
        if (!i_rst_n) begin
            r_su <= '0;
            r_lu <= '0;
            r_lbu <= '0;
            for (int i = 0; i < LONG_DEPTH; i++) begin
                r_long[i].marking  <= MARK_NONE;
                r_lbase[i].marking <= MARK_NONE;
            end
        end else begin
            unique case (i_ctl.cmd)
                C_LATCH: r_in <= i_pic;
                C_INSERT: begin
                    for (int i = SHORT_DEPTH - 1; i > 0; i--) r_short[i] <= r_short[i-1];
                    r_short[0] <= r_in;
                    r_su <= r_su + 1'b1;
                end
                C_KEY_LAST, C_KEY_SCAN: begin
                    r_knum <= w_s.num;
                    r_kbase <= w_s.base;
                end
                C_SHIFT: begin
                    // one step of compaction toward the front
                    if (32'(i_ctl.sidx) + 1 < SHORT_DEPTH)
                        r_short[i_ctl.sidx] <= r_short[SIW'(32'(i_ctl.sidx) + 1)];
                end
                // count falls with the release so every transfer shows the final count
                C_REL_SHORT: r_su <= r_su - 1'b1;
                C_TO_LONG: begin
                    r_su <= r_su - 1'b1;
                    if (i_ctl.ltab) begin
                        r_lbase[i_ctl.lidx] <= w_s;
                        if (r_lbu < CW'(LONG_DEPTH)) r_lbu <= r_lbu + 1'b1;
                    end else begin
                        r_long[i_ctl.lidx] <= w_s;
                        if (r_lu < CW'(LONG_DEPTH)) r_lu <= r_lu + 1'b1;
                    end
                end
                C_RM_LONG: begin
                    if (i_ctl.ltab) begin
                        r_lbase[i_ctl.lidx].marking <= MARK_NONE;
                        if (r_lbu != 0) r_lbu <= r_lbu - 1'b1;
                    end else begin
                        r_long[i_ctl.lidx].marking <= MARK_NONE;
                        if (r_lu != 0) r_lu <= r_lu - 1'b1;
                    end
                end
                C_CLR_LONG: begin
                    if (i_ctl.ltab) r_lbase[i_ctl.lidx].marking <= MARK_NONE;
                    else r_long[i_ctl.lidx].marking <= MARK_NONE;
                end
                C_CLR_ALL: begin
                    r_su <= '0;
                    r_lu <= '0;
                    r_lbu <= '0;
                end
                default: ;
            endcase
        end
        if (i_rst_n && w_emit) begin
            o_valid <= 1'b1;
            o_release_valid <= i_rel;
            o_last <= i_last;
            o_status <= i_status;
            o_release_handle  <= !i_rel ? 8'd0 : i_ctl.rel_short ? w_s.handle : w_l.handle;
            o_release_layer   <= !i_rel ? 3'd0 : i_ctl.rel_short ? w_s.layer : w_l.layer;
            o_release_samples <= !i_rel ? 1'b0 : i_ctl.rel_short ? w_s.shown : w_l.shown;
        end
    end

    assign o_short_count = r_su;
    assign o_long_count = r_lu;
    assign o_long_base_count = r_lbu;
endmodule
`default_nettype wire

>>> sv/rplm_ctrl.sv
// ----------------------------------------------------------------------------
// rplm_ctrl
// sequencer that walks the lists one entry per cycle, a used long entry read again after its release
// ----------------------------------------------------------------------------
`default_nettype none
module rplm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [2:0]     i_operation,
    input  wire logic           i_base_flag,
    input  wire logic [3:0]     i_long_index,
    input  wire rplm_pkg::t_sts i_sts,
    output rplm_pkg::t_ctl      o_ctl,
    output logic                o_rel,
    output logic                o_last,
    output logic [1:0]          o_status,
    output logic                o_busy
);
    import rplm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_UNUSED, S_FIND, S_REL, S_SHIFT, S_TOLONG,
        S_CLR_S, S_CLR_L, S_CLR_LREL, S_DONE, S_FIN
    } t_state;

    t_state r_state;
    logic [2:0] r_op;
    logic r_base;
    logic [3:0] r_li;
    logic [SIW-1:0] r_si;
    logic [LIW-1:0] r_lj;
    logic r_tab, r_key;
    logic [1:0] r_st;
    logic [CW-1:0] r_n;  // short entries to release in clear all

    // last valid short index
    logic [SIW-1:0] w_lastidx;
    logic w_at_end;
    logic w_clr_end;
    assign w_lastidx = SIW'(i_sts.short_used - 1'b1);
    assign w_at_end  = (CW'(r_si) + 1'b1) >= i_sts.short_used;
    assign w_clr_end = (CW'(r_si) + 1'b1) >= r_n;

    always_comb begin
        o_ctl = '0;
        o_ctl.sidx = r_si;
        o_ctl.lidx = r_lj;
        o_ctl.ltab = r_tab;
        o_ctl.use_key = r_key;
        o_rel = 1'b0;
        o_last = 1'b0;
        o_status = r_st;
        unique case (r_state)
            S_IDLE: if (i_start) o_ctl.cmd = C_LATCH;
            S_FIND, S_UNUSED: o_ctl.cmd = C_NONE;
            S_REL: begin
                o_ctl.cmd = C_REL_SHORT;
                o_ctl.rel_short = 1'b1;
                o_rel = 1'b1;
            end
            S_CLR_S: begin
                o_ctl.cmd = C_EMIT;
                o_ctl.rel_short = 1'b1;
                o_rel = 1'b1;
            end
            S_CLR_LREL: begin
                o_ctl.cmd = C_CLR_LONG;
                o_rel = 1'b1;
            end
            // count already lowered, so entries below it still need a step
            S_SHIFT: o_ctl.cmd = (CW'(r_si) < i_sts.short_used) ? C_SHIFT : C_NONE;
            S_FIN: begin
                o_ctl.cmd = C_EMIT;
                o_last = 1'b1;
            end
            default: ;
        endcase
        // side actions decided in the clocked block are issued here
        if (r_state == S_DISPATCH) begin
            unique case (r_op)
                OP_INSERT: if (i_sts.short_used < CW'(SHORT_DEPTH)) o_ctl.cmd = C_INSERT;
                OP_SLIDE: begin
                    o_ctl.sidx = w_lastidx;
                    o_ctl.cmd = C_KEY_LAST;
                end
                OP_RM_LONG: begin
                    o_ctl.lidx = r_li[LIW-1:0];
                    o_ctl.ltab = r_base;
                end
                OP_CLEAR: o_ctl.cmd = C_CLR_ALL;
                default: ;
            endcase
        end
        if (r_state == S_UNUSED && i_sts.short_used != 0) begin
            if (i_sts.short_unused) begin
                o_ctl.cmd = C_KEY_SCAN;
            end else if (w_at_end) begin
                o_ctl.sidx = w_lastidx;
                o_ctl.cmd = C_KEY_LAST;
            end
        end
        if (r_state == S_TOLONG) begin
            o_ctl.cmd = C_TO_LONG;
            o_ctl.ltab = r_base;
            o_ctl.lidx = r_li[LIW-1:0];
        end
        if (r_state == S_DONE && r_op == OP_RM_LONG && r_st == ST_OK) begin
            // marking cleared together with release
            o_ctl.cmd = C_RM_LONG;
            o_ctl.lidx = r_li[LIW-1:0];
            o_ctl.ltab = r_base;
            o_rel = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_busy <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_op <= i_operation;
                    r_base <= i_base_flag;
                    r_li <= i_long_index;
                    r_si <= '0;
                    r_lj <= '0;
                    r_tab <= 1'b0;
                    r_key <= 1'b0;
                    r_st <= ST_OK;
                    o_busy <= 1'b1;
                    r_state <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    unique case (r_op)
                        OP_INSERT: begin
                            if (i_sts.short_used >= CW'(SHORT_DEPTH)) r_st <= ST_FULL;
                            r_state <= S_FIN;
                        end
                        OP_SLIDE: begin
                            if (i_sts.short_used == 0) begin
                                r_st <= ST_NOMATCH;
                                r_state <= S_FIN;
                            end else begin
                                r_key <= 1'b1;
                                r_state <= S_FIND;
                            end
                        end
                        OP_UNUSED: r_state <= S_UNUSED;
                        OP_RM_SHORT, OP_TO_LONG: r_state <= S_FIND;
                        OP_RM_LONG: begin
                            r_lj <= r_li[LIW-1:0];
                            r_tab <= r_base;
                            if (32'(r_li) >= LONG_DEPTH || !i_sts.long_used3)
                                r_st <= ST_NOMATCH;
                            r_state <= S_DONE;
                        end
                        OP_CLEAR: begin
                            r_n <= i_sts.short_used;
                            r_state <= (i_sts.short_used != 0) ? S_CLR_S : S_CLR_L;
                        end
                        default: r_state <= S_FIN;
                    endcase
                end
                S_UNUSED: begin
                    if (i_sts.short_used == 0) begin
                        r_st <= ST_NOMATCH;
                        r_state <= S_FIN;
                    end else if (i_sts.short_unused || w_at_end) begin
                        // unused entry found, or fall back to the sliding window
                        r_si <= '0;
                        r_key <= 1'b1;
                        r_state <= S_FIND;
                    end else r_si <= r_si + 1'b1;
                end
                S_FIND: begin
                    if (CW'(r_si) >= i_sts.short_used) begin
                        r_st <= ST_NOMATCH;
                        r_state <= S_FIN;
                    end else if (i_sts.short_match) begin
                        if (r_op == OP_TO_LONG)
                            r_state <= (32'(r_li) >= LONG_DEPTH) ? S_FIN : S_TOLONG;
                        else r_state <= S_REL;
                        if (r_op == OP_TO_LONG && 32'(r_li) >= LONG_DEPTH)
                            r_st <= ST_NOMATCH;
                    end else if (w_at_end) begin
                        r_st <= ST_NOMATCH;
                        r_state <= S_FIN;
                    end else r_si <= r_si + 1'b1;
                end
                S_REL, S_TOLONG: r_state <= S_SHIFT;
                S_SHIFT: begin
                    if (w_at_end) r_state <= S_FIN;
                    else r_si <= r_si + 1'b1;
                end
                S_CLR_S: begin
                    if (w_clr_end) r_state <= S_CLR_L;
                    else r_si <= r_si + 1'b1;
                end
                S_CLR_L: begin
                    if (i_sts.long_used3) r_state <= S_CLR_LREL;
                    else if (r_lj == LIW'(LONG_DEPTH - 1)) begin
                        if (r_tab) r_state <= S_DONE;
                        else begin
                            r_tab <= 1'b1;
                            r_lj <= '0;
                        end
                    end else r_lj <= r_lj + 1'b1;
                end
                // same slot is read again with its marking now cleared
                S_CLR_LREL: r_state <= S_CLR_L;
                S_DONE: r_state <= S_FIN;
                S_FIN: begin
                    o_busy <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> sv/reference_picture_list_manager.sv
// at most one release per cycle
// throughput: one operation at a time, busy high from acceptance until the closing result
// the list walk in the sequencer goes one entry per cycle, a used long entry read again after
// its release; no result stalls
// reset: synchronous active-low; counts and long markings cleared at once
// ----------------------------------------------------------------------------
// reference_picture_list_manager
// short and long term reference list keeper with release events
// ----------------------------------------------------------------------------
`default_nettype none
module reference_picture_list_manager (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_operation,
    input  wire logic signed [16:0] i_picture_number,
    input  wire logic        i_base_flag,
    input  wire logic [3:0]  i_long_index,
    input  wire logic [7:0]  i_buffer_handle,
    input  wire logic [2:0]  i_layer_number,
    input  wire logic        i_shown_flag,
    input  wire logic [1:0]  i_marking,
    output logic             o_strobe,
    output logic             o_release_valid,
    output logic [7:0]       o_release_handle,
    output logic [2:0]       o_release_layer,
    output logic             o_release_samples,
    output logic [4:0]       o_short_count,
    output logic [4:0]       o_long_count,
    output logic [4:0]       o_long_base_count,
    output logic [1:0]       o_status,
    output logic             o_last
);
    import rplm_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;
    t_pic w_pic;
    logic w_rel, w_last;
    logic [1:0] w_st;

    assign w_pic = '{num: i_picture_number, base: i_base_flag, marking: i_marking,
                     handle: i_buffer_handle, layer: i_layer_number, shown: i_shown_flag};

    rplm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_operation, .i_base_flag, .i_long_index,
        .i_sts(w_sts), .o_ctl(w_ctl), .o_rel(w_rel), .o_last(w_last),
        .o_status(w_st), .o_busy(busy)
    );

    rplm_datapath u_dp (
        .i_clk, .i_rst_n, .i_ctl(w_ctl), .i_pic(w_pic),
        .i_rel(w_rel), .i_last(w_last), .i_status(w_st), .o_sts(w_sts),
        .o_valid(o_strobe), .o_release_valid, .o_release_handle, .o_release_layer,
        .o_release_samples, .o_short_count, .o_long_count, .o_long_base_count,
        .o_status, .o_last
    );
endmodule
`default_nettype wire

>>> sv/rplm_checker.sv
// ----------------------------------------------------------------------------
// rplm_checker
// port-level checks of the reference picture list manager
// ----------------------------------------------------------------------------
`default_nettype none
`include "reference_picture_list_manager_assert.svh"
module rplm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_strobe,
    input wire logic       o_release_valid,
    input wire logic       o_last,
    input wire logic [1:0] o_status,
    input wire logic [4:0] o_short_count
);
    `RPL_ASSERT_IMP(a_strobe_busy, o_strobe && !o_last, busy)
    `RPL_ASSERT_IMP(a_last_norel, o_strobe && o_last, !o_release_valid)
    `RPL_ASSERT_IMP(a_last_frees, o_strobe && o_last, !busy)
    `RPL_ASSERT_IMP(a_count_range, 1'b1, o_short_count <= 5'd16)
endmodule
bind reference_picture_list_manager rplm_checker u_chk (
    .i_clk, .i_rst_n, .start, .busy, .o_strobe, .o_release_valid, .o_last,
    .o_status, .o_short_count
);
`default_nettype wire
